[rtl/c3br_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3br_pkg: shared definitions for the 3x3 convolution unit
// Field widths, stream packing offsets, operation and register codes, and the
// control structs that pass between the sequencer, the stores and the MAC.
// ----------------------------------------------------------------------------
package c3br_pkg;

  // Field widths of one request.
  localparam int OP_W    = 2;
  localparam int CHAN_W  = 4;
  localparam int POS_W   = 5;
  localparam int TAP_W   = 4;
  localparam int VALUE_W = 16;

  // Field widths of one result.
  localparam int ACT_W = 15;

  // Kernel geometry.
  localparam int TAPS = 9;

  // Saturation limit of the activation.
  localparam logic [ACT_W-1:0] ACT_MAX = 15'h7fff;

  // Slave-side tdata packing, lowest field first; tuser carries the operation.
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = OP_W;
  localparam int OFS_OUT_CH = 0;
  localparam int OFS_IN_CH  = OFS_OUT_CH + CHAN_W;
  localparam int OFS_ROW    = OFS_IN_CH + CHAN_W;
  localparam int OFS_COL    = OFS_ROW + POS_W;
  localparam int OFS_TAP    = OFS_COL + POS_W;
  localparam int OFS_VALUE  = OFS_TAP + TAP_W;

  // Master-side tdata carries the activation, padded to two bytes.
  localparam int M_TDATA_W = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WR_TAP  = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_BIAS = 2'd1;
  localparam logic [OP_W-1:0] OP_WR_SAMP = 2'd2;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 2'd3;

  // Register widths and reset values.
  localparam int CNT_CFG_W = 5;
  localparam int DIM_CFG_W = 6;
  localparam logic [CNT_CFG_W-1:0] IN_CHANNELS_RST  = 5'd1;
  localparam logic [DIM_CFG_W-1:0] IMAGE_HEIGHT_RST = 6'd32;
  localparam logic [DIM_CFG_W-1:0] IMAGE_WIDTH_RST  = 6'd32;
  localparam logic [CNT_CFG_W-1:0] OUT_CHANNELS_RST = 5'd1;

  // Write enables of the three stores.
  typedef struct packed {
    logic kern_we;
    logic bias_we;
    logic samp_we;
  } store_we_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic load;    // accumulator takes the bias scaled to Q16.16
    logic mul_en;  // operands are valid and inside the image
  } mac_ctrl_t;

endpackage

[rtl/c3br_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3br_store: kernel, bias and sample memories
// Three single-port-write, single-port-read memories with registered read data.
// ----------------------------------------------------------------------------
module c3br_store #(
  parameter int KERN_DEPTH = 2304,
  parameter int BIAS_DEPTH = 16,
  parameter int SAMP_DEPTH = 16384,
  localparam int KADDR_W = $clog2(KERN_DEPTH),
  localparam int BADDR_W = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1,
  localparam int SADDR_W = $clog2(SAMP_DEPTH)
) (
  input  logic                                 clk_i,
  input  c3br_pkg::store_we_t                  we_i,
  input  logic               [KADDR_W-1:0]     kern_waddr_i,
  input  logic               [BADDR_W-1:0]     bias_waddr_i,
  input  logic               [SADDR_W-1:0]     samp_waddr_i,
  input  logic signed [c3br_pkg::VALUE_W-1:0]  wdata_i,
  input  logic               [KADDR_W-1:0]     kern_raddr_i,
  input  logic               [BADDR_W-1:0]     bias_raddr_i,
  input  logic               [SADDR_W-1:0]     samp_raddr_i,
  output logic signed [c3br_pkg::VALUE_W-1:0]  kern_rdata_o,
  output logic signed [c3br_pkg::VALUE_W-1:0]  bias_rdata_o,
  output logic signed [c3br_pkg::VALUE_W-1:0]  samp_rdata_o
);

  logic signed [c3br_pkg::VALUE_W-1:0] kern_mem [KERN_DEPTH];
  logic signed [c3br_pkg::VALUE_W-1:0] bias_mem [BIAS_DEPTH];
  logic signed [c3br_pkg::VALUE_W-1:0] samp_mem [SAMP_DEPTH];

  // Kernel taps.
  always_ff @(posedge clk_i) begin
    if (we_i.kern_we) begin
      kern_mem[kern_waddr_i] <= wdata_i;
    end
    kern_rdata_o <= kern_mem[kern_raddr_i];
  end

  // Biases.
  always_ff @(posedge clk_i) begin
    if (we_i.bias_we) begin
      bias_mem[bias_waddr_i] <= wdata_i;
    end
    bias_rdata_o <= bias_mem[bias_raddr_i];
  end

  // Input samples.
  always_ff @(posedge clk_i) begin
    if (we_i.samp_we) begin
      samp_mem[samp_waddr_i] <= wdata_i;
    end
    samp_rdata_o <= samp_mem[samp_raddr_i];
  end

endmodule

[rtl/c3br_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3br_mac: shared multiply-accumulate unit
// One 16x16 signed multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module c3br_mac #(
  parameter int ACC_W = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  c3br_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [c3br_pkg::VALUE_W-1:0] bias_i,
  input  logic signed [c3br_pkg::VALUE_W-1:0] tap_i,
  input  logic signed [c3br_pkg::VALUE_W-1:0] samp_i,
  output logic signed [ACC_W-1:0]             acc_o
);

  localparam int PROD_W = 2 * c3br_pkg::VALUE_W;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Product stage: register after the multiplier.
  always_ff @(posedge clk_i) begin
    prod_q <= tap_i * samp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  // Accumulator: the bias enters as Q16.16, products are added one a cycle while valid.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= {{(ACC_W-c3br_pkg::VALUE_W-8){bias_i[c3br_pkg::VALUE_W-1]}}, bias_i, 8'h00};
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign acc_o = acc_q;

endmodule

[rtl/conv3x3_bias_relu_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_bias_relu_unit: 3x3 multi-channel convolution with bias and ReLU
// Stores kernels, biases and input samples and computes one zero-padded output
// sample per compute request with a single shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel; tuser holds the operation (write
//   tap, write bias, write sample, compute). A write gives no result and
//   leaves the unit ready for the next request. A compute request gives one result on m_axis: the
//   activation in tdata and an error flag in tuser.
//   The cfg channel writes the four size registers; it is always ready and
//   is meant to be written only while no compute request is in progress.
// Timing:
//   A compute loads the bias, walks nine taps for each input channel in use
//   through the one multiplier, one tap a cycle, drains and loads the output
//   register; s_axis_tready returns in the same cycle as the result appears
//   there. A compute with bad coordinates skips the bias load, the walk and
//   the drain.
//   The output register lets the next request enter while a result waits;
//   a second compute finishing under a stalled receiver holds until the
//   first result is taken.
// Reset:
//   Reset restores the size registers and empties the output register. The
//   stores are not cleared; their contents are undefined until written.
// ----------------------------------------------------------------------------
module conv3x3_bias_relu_unit #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_OUT_CHANNELS = 16,
  parameter int MAX_HEIGHT       = 32,
  parameter int MAX_WIDTH        = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Requests.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: out_channel, in_channel, row, col, tap, value, two zero bits
  input  logic [c3br_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // tuser: operation
  input  logic [c3br_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  // Results.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: activation, one zero bit
  output logic [c3br_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // tuser: error
  output logic                                m_axis_tuser,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [c3br_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [c3br_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int KERN_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * c3br_pkg::TAPS;
  localparam int SAMP_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int KADDR_W    = $clog2(KERN_DEPTH);
  localparam int BADDR_W    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int SADDR_W    = $clog2(SAMP_DEPTH);
  localparam int CH_W       = $clog2(MAX_IN_CHANNELS + 1);
  localparam int DIM_W      = 9;
  localparam int ACC_W      = 2 * c3br_pkg::VALUE_W
                              + $clog2(MAX_IN_CHANNELS * c3br_pkg::TAPS + 1) + 1;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BIAS   = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // Request fields.
  logic [c3br_pkg::OP_W-1:0]           op;
  logic [c3br_pkg::CHAN_W-1:0]         f_oc;
  logic [c3br_pkg::CHAN_W-1:0]         f_ic;
  logic [c3br_pkg::POS_W-1:0]          f_row;
  logic [c3br_pkg::POS_W-1:0]          f_col;
  logic [c3br_pkg::TAP_W-1:0]          f_tap;
  logic signed [c3br_pkg::VALUE_W-1:0] f_value;

  assign op      = s_axis_tuser;
  assign f_oc    = s_axis_tdata[c3br_pkg::OFS_OUT_CH +: c3br_pkg::CHAN_W];
  assign f_ic    = s_axis_tdata[c3br_pkg::OFS_IN_CH  +: c3br_pkg::CHAN_W];
  assign f_row   = s_axis_tdata[c3br_pkg::OFS_ROW    +: c3br_pkg::POS_W];
  assign f_col   = s_axis_tdata[c3br_pkg::OFS_COL    +: c3br_pkg::POS_W];
  assign f_tap   = s_axis_tdata[c3br_pkg::OFS_TAP    +: c3br_pkg::TAP_W];
  assign f_value = s_axis_tdata[c3br_pkg::OFS_VALUE  +: c3br_pkg::VALUE_W];

  logic [2:0]                     state_q, state_d;
  logic [c3br_pkg::CNT_CFG_W-1:0] in_ch_q, out_ch_q;
  logic [c3br_pkg::DIM_CFG_W-1:0] height_q, width_q;
  logic [c3br_pkg::CHAN_W-1:0]    oc_q, oc_d;
  logic [c3br_pkg::POS_W-1:0]     row_q, row_d, col_q, col_d;
  logic [CH_W-1:0]                ch_q, ch_d;
  logic [c3br_pkg::TAP_W-1:0]     t_q, t_d;
  logic [1:0]                     kr_q, kr_d, kc_q, kc_d;
  logic                           drain_q, drain_d;
  logic                           err_q, err_d;
  logic                           rd_vld_q, rd_vld_d;
  logic                           out_vld_q;
  logic [c3br_pkg::ACT_W-1:0]     out_act_q;
  logic                           out_err_q;

  logic                           s_req;
  logic                           out_load;
  logic [DIM_W-1:0]               nin_c, nout_c, h_c, w_c;
  logic                           coord_bad;
  logic [c3br_pkg::POS_W:0]       sr_sum, sc_sum;
  logic                           pos_ok;
  logic                           last_tap;
  logic                           last_ch;

  c3br_pkg::store_we_t            store_we;
  c3br_pkg::mac_ctrl_t            mac_ctrl;
  logic [KADDR_W-1:0]             kern_waddr, kern_raddr;
  logic [BADDR_W-1:0]             bias_waddr, bias_raddr;
  logic [SADDR_W-1:0]             samp_waddr, samp_raddr;
  logic signed [c3br_pkg::VALUE_W-1:0] kern_rdata, bias_rdata, samp_rdata;
  logic signed [ACC_W-1:0]        acc;
  logic [c3br_pkg::ACT_W-1:0]     act;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_req         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= c3br_pkg::IN_CHANNELS_RST;
      height_q <= c3br_pkg::IMAGE_HEIGHT_RST;
      width_q  <= c3br_pkg::IMAGE_WIDTH_RST;
      out_ch_q <= c3br_pkg::OUT_CHANNELS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        c3br_pkg::REG_IN_CHANNELS: begin
          in_ch_q <= cfg_data_i[c3br_pkg::CNT_CFG_W-1:0];
        end
        c3br_pkg::REG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i;
        end
        c3br_pkg::REG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i;
        end
        c3br_pkg::REG_OUT_CHANNELS: begin
          out_ch_q <= cfg_data_i[c3br_pkg::CNT_CFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Sizes in use, limited to what the stores hold.
  always_comb begin
    nin_c  = (DIM_W'(in_ch_q) > DIM_W'(MAX_IN_CHANNELS)) ?
             DIM_W'(MAX_IN_CHANNELS) : DIM_W'(in_ch_q);
    nout_c = (DIM_W'(out_ch_q) > DIM_W'(MAX_OUT_CHANNELS)) ?
             DIM_W'(MAX_OUT_CHANNELS) : DIM_W'(out_ch_q);
    h_c    = (DIM_W'(height_q) > DIM_W'(MAX_HEIGHT)) ?
             DIM_W'(MAX_HEIGHT) : DIM_W'(height_q);
    w_c    = (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) ?
             DIM_W'(MAX_WIDTH) : DIM_W'(width_q);
  end

  assign coord_bad = (DIM_W'(f_oc) >= nout_c) || (DIM_W'(f_row) >= h_c) ||
                     (DIM_W'(f_col) >= w_c);

  // Store writes from write requests; out-of-store writes are dropped.
  always_comb begin
    store_we = '0;
    if (s_req) begin
      unique case (op)
        c3br_pkg::OP_WR_TAP: begin
          store_we.kern_we = (32'(f_oc) < MAX_OUT_CHANNELS) &&
                             (32'(f_ic) < MAX_IN_CHANNELS) &&
                             (32'(f_tap) < c3br_pkg::TAPS);
        end
        c3br_pkg::OP_WR_BIAS: begin
          store_we.bias_we = (32'(f_oc) < MAX_OUT_CHANNELS);
        end
        c3br_pkg::OP_WR_SAMP: begin
          store_we.samp_we = (32'(f_ic) < MAX_IN_CHANNELS) &&
                             (32'(f_row) < MAX_HEIGHT) && (32'(f_col) < MAX_WIDTH);
        end
        default: begin
        end
      endcase
    end
  end

  assign kern_waddr = KADDR_W'((32'(f_oc) * MAX_IN_CHANNELS + 32'(f_ic)) * c3br_pkg::TAPS
                               + 32'(f_tap));
  assign bias_waddr = BADDR_W'(32'(f_oc));
  assign samp_waddr = SADDR_W'((32'(f_ic) * MAX_HEIGHT + 32'(f_row)) * MAX_WIDTH
                               + 32'(f_col));

  // Neighbor position of the current tap; sums are position plus one.
  assign sr_sum = {1'b0, row_q} + {{(c3br_pkg::POS_W-1){1'b0}}, kr_q};
  assign sc_sum = {1'b0, col_q} + {{(c3br_pkg::POS_W-1){1'b0}}, kc_q};
  assign pos_ok = (sr_sum != '0) && (DIM_W'(sr_sum) <= h_c) &&
                  (sc_sum != '0) && (DIM_W'(sc_sum) <= w_c);

  // Read addresses: bias follows the request during idle, the walk drives the rest.
  assign bias_raddr = (state_q == ST_IDLE) ? BADDR_W'(32'(f_oc)) : BADDR_W'(32'(oc_q));
  assign kern_raddr = KADDR_W'((32'(oc_q) * MAX_IN_CHANNELS + 32'(ch_q)) * c3br_pkg::TAPS
                               + 32'(t_q));
  assign samp_raddr = SADDR_W'((32'(ch_q) * MAX_HEIGHT + 32'(sr_sum) - 32'd1) * MAX_WIDTH
                               + 32'(sc_sum) - 32'd1);

  assign last_tap = (t_q == c3br_pkg::TAP_W'(c3br_pkg::TAPS - 1));
  assign last_ch  = (DIM_W'(ch_q) + DIM_W'(1) == nin_c);
  assign out_load = (state_q == ST_FINISH) && (!out_vld_q || m_axis_tready);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    oc_d     = oc_q;
    row_d    = row_q;
    col_d    = col_q;
    ch_d     = ch_q;
    t_d      = t_q;
    kr_d     = kr_q;
    kc_d     = kc_q;
    drain_d  = drain_q;
    err_d    = err_q;
    rd_vld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_req && (op == c3br_pkg::OP_COMPUTE)) begin
          oc_d  = f_oc;
          row_d = f_row;
          col_d = f_col;
          ch_d  = '0;
          t_d   = '0;
          kr_d  = '0;
          kc_d  = '0;
          err_d = coord_bad;
          state_d = coord_bad ? ST_FINISH : ST_BIAS;
        end
      end
      ST_BIAS: begin
        drain_d = 1'b0;
        state_d = (nin_c == '0) ? ST_DRAIN : ST_WALK;
      end
      ST_WALK: begin
        rd_vld_d = pos_ok;
        if (kc_q == 2'd2) begin
          kc_d = 2'd0;
          kr_d = kr_q + 2'd1;
        end else begin
          kc_d = kc_q + 2'd1;
        end
        t_d = t_q + 1'b1;
        if (last_tap) begin
          t_d  = '0;
          kr_d = 2'd0;
          kc_d = 2'd0;
          ch_d = ch_q + 1'b1;
          if (last_ch) begin
            drain_d = 1'b0;
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      drain_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      drain_q  <= drain_d;
    end
  end

  // Walk position and request coordinates.
  always_ff @(posedge clk_i) begin
    oc_q  <= oc_d;
    row_q <= row_d;
    col_q <= col_d;
    ch_q  <= ch_d;
    t_q   <= t_d;
    kr_q  <= kr_d;
    kc_q  <= kc_d;
    err_q <= err_d;
  end

  c3br_store #(
    .KERN_DEPTH (KERN_DEPTH),
    .BIAS_DEPTH (MAX_OUT_CHANNELS),
    .SAMP_DEPTH (SAMP_DEPTH)
  ) u_store (
    .clk_i        (clk_i),
    .we_i         (store_we),
    .kern_waddr_i (kern_waddr),
    .bias_waddr_i (bias_waddr),
    .samp_waddr_i (samp_waddr),
    .wdata_i      (f_value),
    .kern_raddr_i (kern_raddr),
    .bias_raddr_i (bias_raddr),
    .samp_raddr_i (samp_raddr),
    .kern_rdata_o (kern_rdata),
    .bias_rdata_o (bias_rdata),
    .samp_rdata_o (samp_rdata)
  );

  assign mac_ctrl.load   = (state_q == ST_BIAS);
  assign mac_ctrl.mul_en = rd_vld_q;

  c3br_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .bias_i (bias_rdata),
    .tap_i  (kern_rdata),
    .samp_i (samp_rdata),
    .acc_o  (acc)
  );

  // Shift by 8 with floor, clamp negatives and error results to zero and saturate the top.
  always_comb begin
    if (err_q || acc[ACC_W-1]) begin
      act = '0;
    end else if (|acc[ACC_W-2:c3br_pkg::ACT_W+8]) begin
      act = c3br_pkg::ACT_MAX;
    end else begin
      act = acc[c3br_pkg::ACT_W+7:8];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_act_q <= act;
      out_err_q <= err_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_act_q};
  assign m_axis_tuser  = out_err_q;

endmodule

[rtl/c3br_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3br_checker: port-level checks for the convolution unit
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module c3br_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_tvalid_i,
  input logic                             s_tready_i,
  input logic [c3br_pkg::S_TUSER_W-1:0]   s_tuser_i,
  input logic                             m_tvalid_i,
  input logic                             m_tready_i,
  input logic [c3br_pkg::M_TDATA_W-1:0]   m_tdata_i,
  input logic                             m_tuser_i
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("result changed while stalled");

  // An error result carries a zero activation and a zero pad bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> m_tdata_i == '0)
    else $error("error result with nonzero activation");

  // The pad bit above the activation stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> !m_tdata_i[c3br_pkg::M_TDATA_W-1])
    else $error("activation pad bit set");

  // A compute request keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i && (s_tuser_i == c3br_pkg::OP_COMPUTE) |=> !s_tready_i)
    else $error("ready right after a compute request");

  // A write request leaves the block ready for the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i && (s_tuser_i != c3br_pkg::OP_COMPUTE) |=> s_tready_i)
    else $error("not ready after a write request");

endmodule

bind conv3x3_bias_relu_unit c3br_checker u_c3br_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .s_tuser_i  (s_axis_tuser),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for conv3x3_bias_relu_unit
// Fills every kernel, bias and sample entry first, then runs a directed table
// and several random phases under different size settings. Each result is
// compared with a behavioral convolution predictor kept inside the bench or with a typed-in value.
// ----------------------------------------------------------------------------
module tb;
  import c3br_pkg::*;

  localparam int MAX_CH      = 16;
  localparam int MAX_H       = 32;
  localparam int MAX_W       = 32;
  localparam int DRAIN_WAIT  = 200;       // longer than a compute over sixteen input channels
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int N_PHASES    = 5;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_AT     = 30;        // result count that starts the long hold-off
  localparam int LONG_HOLD   = 500;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [CHAN_W-1:0]  oc;
    logic [CHAN_W-1:0]  ic;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [TAP_W-1:0]   tap;
    logic [VALUE_W-1:0] value;
  } conv_req_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             err;
  } conv_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    conv_req_t              rq;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     typed;
    conv_result_t           res;
  } tbl_row_t;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [S_TDATA_W-1:0]    s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0]    s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]    m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;

  // Predictor state: the three stores and the size registers.
  logic signed [VALUE_W-1:0] tap_store  [MAX_CH][MAX_CH][TAPS];
  logic signed [VALUE_W-1:0] bias_store [MAX_CH];
  logic signed [VALUE_W-1:0] samp_store [MAX_CH][MAX_H][MAX_W];
  logic [CNT_CFG_W-1:0] reg_in_ch  = IN_CHANNELS_RST;
  logic [DIM_CFG_W-1:0] reg_height = IMAGE_HEIGHT_RST;
  logic [DIM_CFG_W-1:0] reg_width  = IMAGE_WIDTH_RST;
  logic [CNT_CFG_W-1:0] reg_out_ch = OUT_CHANNELS_RST;

  conv_result_t pending_results[$];
  tbl_row_t     dir_tbl[$];

  bit idle_en    = 1'b1;
  int err_cnt    = 0;
  int n_req      = 0;
  int n_results  = 0;
  int n_bad      = 0;
  int n_sat      = 0;
  int n_clipped  = 0;
  int n_cfg      = 0;
  int cycle_cnt  = 0;

  conv3x3_bias_relu_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_size(int v, int top);
    return (v > top) ? top : v;
  endfunction

  function automatic conv_req_t mk_req(logic [OP_W-1:0] op, int oc, int ic, int row,
                                       int col, int tap, int value);
    conv_req_t r;
    r.op    = op;
    r.oc    = oc[CHAN_W-1:0];
    r.ic    = ic[CHAN_W-1:0];
    r.row   = row[POS_W-1:0];
    r.col   = col[POS_W-1:0];
    r.tap   = tap[TAP_W-1:0];
    r.value = value[VALUE_W-1:0];
    return r;
  endfunction

  function automatic int small_value();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  // Table rows: a request checked by the predictor, a request with its result
  // typed in, and a register write.
  function automatic tbl_row_t req_row(conv_req_t rq);
    tbl_row_t t;
    t.kind  = ROW_REQ;
    t.rq    = rq;
    t.idx   = '0;
    t.data  = '0;
    t.typed = 1'b0;
    t.res   = '0;
    return t;
  endfunction

  function automatic tbl_row_t chk_row(conv_req_t rq, int act, bit err);
    tbl_row_t t;
    t.kind  = ROW_REQ;
    t.rq    = rq;
    t.idx   = '0;
    t.data  = '0;
    t.typed = 1'b1;
    t.res   = '{act: act[ACT_W-1:0], err: err};
    return t;
  endfunction

  function automatic tbl_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int data);
    tbl_row_t t;
    t.kind  = ROW_CFG;
    t.rq    = mk_req(OP_WR_TAP, 0, 0, 0, 0, 0, 0);
    t.idx   = idx;
    t.data  = data[CFG_DATA_W-1:0];
    t.typed = 1'b0;
    t.res   = '0;
    return t;
  endfunction

  // Offers one request, waits for it to be taken, then updates the stores or
  // queues the expected activation.
  task automatic issue_request(input conv_req_t rq, input bit typed,
                               input conv_result_t typed_res);
    logic [S_TDATA_W-1:0] word;
    conv_result_t res;
    longint acc;
    int sr, sc, n_in, n_out, h, w;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    word = '0;
    word[OFS_OUT_CH +: CHAN_W] = rq.oc;
    word[OFS_IN_CH +: CHAN_W]  = rq.ic;
    word[OFS_ROW +: POS_W]     = rq.row;
    word[OFS_COL +: POS_W]     = rq.col;
    word[OFS_TAP +: TAP_W]     = rq.tap;
    word[OFS_VALUE +: VALUE_W] = rq.value;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= rq.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_req++;
    case (rq.op)
      OP_WR_TAP: begin
        // Tap indexes past the kernel fall outside the store and are dropped.
        if (rq.tap < TAPS) tap_store[rq.oc][rq.ic][rq.tap] = rq.value;
      end
      OP_WR_BIAS: bias_store[rq.oc] = rq.value;
      OP_WR_SAMP: samp_store[rq.ic][rq.row][rq.col] = rq.value;
      default: begin
        n_in  = eff_size(reg_in_ch, MAX_CH);
        n_out = eff_size(reg_out_ch, MAX_CH);
        h     = eff_size(reg_height, MAX_H);
        w     = eff_size(reg_width, MAX_W);
        if (rq.oc >= n_out || rq.row >= h || rq.col >= w) begin
          res = '{act: '0, err: 1'b1};
        end else begin
          // Exact Q16.16 sum, then floor shift to Q8.8, ReLU and saturation.
          acc = longint'(bias_store[rq.oc]) * 256;
          for (int ch = 0; ch < n_in; ch++) begin
            for (int t = 0; t < TAPS; t++) begin
              sr = int'(rq.row) + t / 3 - 1;
              sc = int'(rq.col) + t % 3 - 1;
              if (sr >= 0 && sc >= 0 && sr < h && sc < w)
                acc += longint'(tap_store[rq.oc][ch][t]) * longint'(samp_store[ch][sr][sc]);
            end
          end
          acc = acc >>> 8;
          if (acc < 0) acc = 0;
          else if (acc > longint'(ACT_MAX)) acc = longint'(ACT_MAX);
          res = '{act: acc[ACT_W-1:0], err: 1'b0};
        end
        pending_results.push_back(typed ? typed_res : res);
      end
    endcase
  endtask

  // Register writes happen only once all results are back and the unit is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    n_cfg++;
    case (idx)
      REG_IN_CHANNELS:  reg_in_ch  = data[CNT_CFG_W-1:0];
      REG_IMAGE_HEIGHT: reg_height = data[DIM_CFG_W-1:0];
      REG_IMAGE_WIDTH:  reg_width  = data[DIM_CFG_W-1:0];
      default:          reg_out_ch = data[CNT_CFG_W-1:0];
    endcase
  endtask

  // Result checker and receiver backpressure.
  always @(posedge clk_i) begin
    static int stall_left = 0;
    static int hold_left  = 0;
    static bit held_once  = 1'b0;
    conv_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got act=%0d err=%0b",
                 $time, m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res.err) n_bad++;
        else if (exp_res.act == ACT_MAX) n_sat++;
        else if (exp_res.act == '0) n_clipped++;
        if (m_axis_tdata !== {1'b0, exp_res.act} || m_axis_tuser !== exp_res.err) begin
          $display("%0t: result mismatch: expected act=%0d err=%0b, got act=%0d err=%0b",
                   $time, exp_res.act, exp_res.err, m_axis_tdata, m_axis_tuser);
          err_cnt++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!held_once && n_results == HOLD_AT) begin
      // One long hold-off so that the unit fills up and stalls its input.
      held_once = 1'b1;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[conv3x3_bias_relu_unit] ERROR");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    conv_req_t rq;
    int n_in, n_out, h, w, n_item, sel;
    logic [CFG_DATA_W-1:0] cfg_in, cfg_h, cfg_w, cfg_out;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every store entry with a modest value so no read hits an empty entry.
    for (int oc = 0; oc < MAX_CH; oc++) begin
      issue_request(mk_req(OP_WR_BIAS, oc, 0, 0, 0, 0, small_value()), 1'b0, '0);
      for (int ic = 0; ic < MAX_CH; ic++)
        for (int t = 0; t < TAPS; t++)
          issue_request(mk_req(OP_WR_TAP, oc, ic, 0, 0, t, small_value()), 1'b0, '0);
    end
    for (int ic = 0; ic < MAX_CH; ic++)
      for (int r = 0; r < MAX_H; r++)
        for (int c = 0; c < MAX_W; c++)
          issue_request(mk_req(OP_WR_SAMP, ic, ic, r, c, 0, small_value()), 1'b0, '0);

    // Directed table, starting from the reset sizes.
    dir_tbl.push_back(req_row(mk_req(OP_COMPUTE, 0, 0, 0, 0, 0, 0)));
    dir_tbl.push_back(req_row(mk_req(OP_COMPUTE, 0, 0, 31, 31, 0, 0)));
    dir_tbl.push_back(chk_row(mk_req(OP_COMPUTE, 15, 0, 0, 0, 0, 0), 0, 1'b1));
    // Largest positive values drive the sum into saturation.
    dir_tbl.push_back(req_row(mk_req(OP_WR_BIAS, 0, 0, 0, 0, 0, 32767)));
    dir_tbl.push_back(req_row(mk_req(OP_WR_TAP, 0, 0, 0, 0, 4, 32767)));
    dir_tbl.push_back(req_row(mk_req(OP_WR_SAMP, 0, 0, 5, 5, 0, 32767)));
    dir_tbl.push_back(chk_row(mk_req(OP_COMPUTE, 0, 0, 5, 5, 0, 0), 32767, 1'b0));
    // Most negative values give a negative sum that the ReLU clips.
    dir_tbl.push_back(req_row(mk_req(OP_WR_BIAS, 0, 0, 0, 0, 0, -32768)));
    dir_tbl.push_back(req_row(mk_req(OP_WR_TAP, 0, 0, 0, 0, 4, -32768)));
    dir_tbl.push_back(chk_row(mk_req(OP_COMPUTE, 0, 0, 5, 5, 0, 0), 0, 1'b0));
    // Tap writes beyond the kernel must leave the store alone.
    dir_tbl.push_back(req_row(mk_req(OP_WR_TAP, 0, 0, 0, 0, 9, 32767)));
    dir_tbl.push_back(req_row(mk_req(OP_WR_TAP, 0, 0, 0, 0, 15, 16'h5555)));
    dir_tbl.push_back(req_row(mk_req(OP_COMPUTE, 0, 0, 4, 4, 0, 0)));
    // No input channels: the bias alone comes through.
    dir_tbl.push_back(cfg_row(REG_IN_CHANNELS, 0));
    dir_tbl.push_back(req_row(mk_req(OP_WR_BIAS, 0, 0, 0, 0, 0, 16'h0180)));
    dir_tbl.push_back(chk_row(mk_req(OP_COMPUTE, 0, 0, 7, 9, 0, 0), 16'h0180, 1'b0));
    // No output channels: every compute is flagged.
    dir_tbl.push_back(cfg_row(REG_OUT_CHANNELS, 0));
    dir_tbl.push_back(chk_row(mk_req(OP_COMPUTE, 0, 0, 0, 0, 0, 0), 0, 1'b1));
    // All registers written above their range saturate at the maximum sizes.
    dir_tbl.push_back(cfg_row(REG_IN_CHANNELS, 63));
    dir_tbl.push_back(cfg_row(REG_OUT_CHANNELS, 63));
    dir_tbl.push_back(cfg_row(REG_IMAGE_HEIGHT, 63));
    dir_tbl.push_back(cfg_row(REG_IMAGE_WIDTH, 63));
    dir_tbl.push_back(req_row(mk_req(OP_COMPUTE, 15, 0, 31, 31, 0, 0)));
    dir_tbl.push_back(req_row(mk_req(OP_COMPUTE, 15, 0, 16, 0, 0, 0)));
    // A one-by-one image pads every neighbor with zero.
    dir_tbl.push_back(cfg_row(REG_IMAGE_HEIGHT, 1));
    dir_tbl.push_back(cfg_row(REG_IMAGE_WIDTH, 1));
    dir_tbl.push_back(req_row(mk_req(OP_COMPUTE, 3, 0, 0, 0, 0, 0)));
    dir_tbl.push_back(chk_row(mk_req(OP_COMPUTE, 3, 0, 0, 1, 0, 0), 0, 1'b1));
    // Zero rows makes any position bad.
    dir_tbl.push_back(cfg_row(REG_IMAGE_HEIGHT, 0));
    dir_tbl.push_back(chk_row(mk_req(OP_COMPUTE, 3, 0, 0, 0, 0, 0), 0, 1'b1));
    dir_tbl.push_back(req_row(mk_req(OP_WR_SAMP, 0, 15, 31, 31, 0, 16'h8000)));
    dir_tbl.push_back(req_row(mk_req(OP_WR_TAP, 15, 15, 0, 0, 8, 16'h7fff)));

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      else issue_request(dir_tbl[i].rq, dir_tbl[i].typed, dir_tbl[i].res);
    end

    // Random phases: smallest sizes, largest sizes, then random settings.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          cfg_in = 1;
          cfg_h = 2;
          cfg_w = 2;
          cfg_out = 1;
        end
        1: begin
          cfg_in = 16;
          cfg_h = 32;
          cfg_w = 32;
          cfg_out = 16;
        end
        default: begin
          cfg_in  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 16);
          cfg_h   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 32);
          cfg_w   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 32);
          cfg_out = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 16);
        end
      endcase
      idle_en = 1'b1;
      write_reg(REG_IN_CHANNELS, cfg_in);
      write_reg(REG_IMAGE_HEIGHT, cfg_h);
      write_reg(REG_IMAGE_WIDTH, cfg_w);
      write_reg(REG_OUT_CHANNELS, cfg_out);
      n_in  = eff_size(reg_in_ch, MAX_CH);
      n_out = eff_size(reg_out_ch, MAX_CH);
      h     = eff_size(reg_height, MAX_H);
      w     = eff_size(reg_width, MAX_W);
      n_item = 0;
      while (n_item < PHASE_ITEMS) begin
        // The last phase runs without idling; others keep quiet stretches too.
        idle_en = (ph != N_PHASES - 1) && ((n_item % 50) < 35);
        rq = mk_req(OP_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15),
                    ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : small_value());
        sel = $urandom_range(0, 99);
        if (sel < 45) rq.op = OP_COMPUTE;
        else if (sel < 65) rq.op = OP_WR_SAMP;
        else if (sel < 85) rq.op = OP_WR_TAP;
        else rq.op = OP_WR_BIAS;
        // Most requests land inside the configured image and channel counts.
        if (n_out > 0 && h > 0 && w > 0 && $urandom_range(0, 9) < 8) begin
          rq.oc  = $urandom_range(0, n_out - 1);
          rq.row = $urandom_range(0, h - 1);
          rq.col = $urandom_range(0, w - 1);
          rq.tap = $urandom_range(0, TAPS - 1);
          if (n_in > 0) rq.ic = $urandom_range(0, n_in - 1);
        end
        issue_request(rq, 1'b0, '0);
        if (!(rq.op == OP_WR_TAP && rq.tap >= TAPS)) n_item++;
      end
    end

    // Drain and let the unit settle.
    s_axis_tvalid <= 1'b0;
    idle_en = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      err_cnt++;
    end

    $display("Run covered %0d requests and %0d results: %0d bad positions, %0d saturated,",
             n_req, n_results, n_bad, n_sat);
    $display("%0d clipped to zero, across %0d register writes and a %0d-cycle output stall.",
             n_clipped, n_cfg, LONG_HOLD);
    if (err_cnt == 0) begin
      $display("[conv3x3_bias_relu_unit] OK");
    end else begin
      $display("[conv3x3_bias_relu_unit] ERROR");
    end
    $finish;
  end

endmodule
